FILE: hdl/ethernet_frame_classifier_assert.svh
// assertion macros for the ethernet frame classifier checker
// relies on a signal named clk and an active-low reset named rst_n in scope
`ifndef ETHERNET_FRAME_CLASSIFIER_ASSERT_SVH
`define ETHERNET_FRAME_CLASSIFIER_ASSERT_SVH

// property checked only outside reset
`define EFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define EFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/efc_pkg.sv
// types and constants for the ethernet frame classifier
// no dependencies; imported by efc_parser, ethernet_frame_classifier and efc_checker
`timescale 1ns / 1ps

package efc_pkg;

    // ether type / length values
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] DIX_LIMIT   = 16'd1500;
    localparam logic [15:0] NOVELL_WORD = 16'hFFFF;
    localparam logic [15:0] SNAP_WORD   = 16'hAAAA;
    localparam logic [15:0] MIN_IP_LEN  = 16'd20;
    localparam logic [15:0] MIN_LLC_LEN = 16'd2;

    // output stream word: 228 bits of fields padded to whole bytes
    localparam int OUT_TDATA_W = 232;

    typedef enum logic [2:0] {
        KIND_IPV4   = 3'd0,
        KIND_DIX    = 3'd1,
        KIND_NOVELL = 3'd2,
        KIND_SNAP   = 3'd3,
        KIND_LLC    = 3'd4
    } frame_kind_t;

    typedef struct packed {
        logic       step;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] frame_number;
        frame_kind_t frame_kind;
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] kind_count;
        logic        length_raised;
    } result_t;

endpackage

FILE: hdl/efc_parser.sv
// header parser and frame counters of the ethernet frame classifier
// depends on efc_pkg; one byte is consumed per step strobe
`timescale 1ns / 1ps

module efc_parser #(
    parameter int COUNT_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  efc_pkg::in_item_t item,
    output logic             emit,
    output efc_pkg::result_t  result
);
    import efc_pkg::*;

    localparam logic [16:0] OFS_SRC     = 17'd6;
    localparam logic [16:0] OFS_TYPE    = 17'd12;
    localparam logic [16:0] OFS_TYPE_LO = 17'd13;
    localparam logic [16:0] OFS_PAYLOAD = 17'd14;
    localparam logic [16:0] OFS_PEEK_LO = 17'd15;
    localparam logic [16:0] OFS_IPLEN   = 17'd16;
    localparam logic [16:0] OFS_IPLEN_LO = 17'd17;
    localparam logic [16:0] OFS_IPLEN_END = 17'd18;
    localparam logic [16:0] OFS_SRC_IP  = 17'd26;
    localparam logic [16:0] OFS_DST_IP  = 17'd30;
    localparam logic [16:0] OFS_IP_END  = 17'd34;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int KINDS = 5;

    logic [16:0]           pos_reg,    pos_next;
    logic [47:0]           dest_reg,   dest_next;
    logic [47:0]           src_reg,    src_next;
    logic [15:0]           tl_reg,     tl_next;
    logic [15:0]           peek_reg,   peek_next;
    logic [31:0]           ipsrc_reg,  ipsrc_next;
    logic [31:0]           ipdst_reg,  ipdst_next;
    logic [16:0]           end_reg,    end_next;
    logic                  raised_reg, raised_next;
    logic [COUNT_BITS-1:0] total_reg,  total_next;
    logic [COUNT_BITS-1:0] kcnt_reg [KINDS];
    logic [COUNT_BITS-1:0] kcnt_next;

    logic        is_ipv4;
    logic        is_dix;
    frame_kind_t kind;
    logic [63:0] total_wide;
    logic [63:0] kcnt_wide;

    always_comb
    begin
        dest_next   = dest_reg;
        src_next    = src_reg;
        tl_next     = tl_reg;
        peek_next   = peek_reg;
        ipsrc_next  = ipsrc_reg;
        ipdst_next  = ipdst_reg;
        end_next    = end_reg;
        raised_next = raised_reg;

        if (pos_reg < OFS_SRC)
            dest_next = {dest_reg[39:0], item.data_byte};
        else if (pos_reg < OFS_TYPE)
            src_next = {src_reg[39:0], item.data_byte};
        else if (pos_reg < OFS_PAYLOAD)
            tl_next = {tl_reg[7:0], item.data_byte};

        is_ipv4 = (pos_reg >= OFS_PAYLOAD) && (tl_next == ETH_IPV4);
        is_dix  = tl_next > DIX_LIMIT;

        // llc/snap header word, or ip total length for ipv4
        if ((pos_reg >= OFS_PAYLOAD && pos_reg < OFS_IPLEN) ||
            (is_ipv4 && pos_reg >= OFS_IPLEN && pos_reg < OFS_IPLEN_END))
            peek_next = {peek_reg[7:0], item.data_byte};

        if (pos_reg == OFS_TYPE_LO && tl_next != ETH_IPV4 && is_dix)
            end_next = OFS_PAYLOAD + {1'b0, tl_next};

        if (pos_reg == OFS_PEEK_LO && !is_ipv4 && !is_dix)
        begin
            if (tl_next < MIN_LLC_LEN)
            begin
                end_next    = OFS_PAYLOAD + {1'b0, MIN_LLC_LEN};
                raised_next = 1'b1;
            end
            else
                end_next = OFS_PAYLOAD + {1'b0, tl_next};
        end

        if (pos_reg == OFS_IPLEN_LO && is_ipv4)
        begin
            if (peek_next < MIN_IP_LEN)
            begin
                end_next    = OFS_PAYLOAD + {1'b0, MIN_IP_LEN};
                raised_next = 1'b1;
            end
            else
                end_next = OFS_PAYLOAD + {1'b0, peek_next};
        end

        if (is_ipv4 && pos_reg >= OFS_SRC_IP && pos_reg < OFS_DST_IP)
            ipsrc_next = {ipsrc_reg[23:0], item.data_byte};
        if (is_ipv4 && pos_reg >= OFS_DST_IP && pos_reg < OFS_IP_END)
            ipdst_next = {ipdst_reg[23:0], item.data_byte};

        pos_next = pos_reg + 17'd1;
        emit     = (end_next != '0) && (pos_next == end_next);

        if (tl_next == ETH_IPV4)
            kind = KIND_IPV4;
        else if (is_dix)
            kind = KIND_DIX;
        else if (peek_next == NOVELL_WORD)
            kind = KIND_NOVELL;
        else if (peek_next == SNAP_WORD)
            kind = KIND_SNAP;
        else
            kind = KIND_LLC;

        // saturating counters
        total_next = (total_reg == CNT_MAX) ? total_reg : total_reg + 1'b1;
        kcnt_next  = (kcnt_reg[kind] == CNT_MAX) ? kcnt_reg[kind] : kcnt_reg[kind] + 1'b1;
        total_wide = 64'(total_next);
        kcnt_wide  = 64'(kcnt_next);

        result.frame_number  = total_wide[31:0];
        result.frame_kind    = kind;
        result.dest_mac      = dest_next;
        result.src_mac       = src_next;
        result.src_ip        = (kind == KIND_IPV4) ? ipsrc_next : 32'd0;
        result.dst_ip        = (kind == KIND_IPV4) ? ipdst_next : 32'd0;
        result.kind_count    = kcnt_wide[31:0];
        result.length_raised = raised_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            dest_reg   <= '0;
            src_reg    <= '0;
            tl_reg     <= '0;
            peek_reg   <= '0;
            ipsrc_reg  <= '0;
            ipdst_reg  <= '0;
            end_reg    <= '0;
            raised_reg <= 1'b0;
            total_reg  <= '0;
            for (int i = 0; i < KINDS; i++)
                kcnt_reg[i] <= '0;
        end
        else if (item.step)
        begin
            if (item.last_byte || emit)
            begin
                // end of capture or end of frame: start the next frame clean
                pos_reg    <= '0;
                dest_reg   <= '0;
                src_reg    <= '0;
                tl_reg     <= '0;
                peek_reg   <= '0;
                ipsrc_reg  <= '0;
                ipdst_reg  <= '0;
                end_reg    <= '0;
                raised_reg <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                dest_reg   <= dest_next;
                src_reg    <= src_next;
                tl_reg     <= tl_next;
                peek_reg   <= peek_next;
                ipsrc_reg  <= ipsrc_next;
                ipdst_reg  <= ipdst_next;
                end_reg    <= end_next;
                raised_reg <= raised_next;
            end

            if (item.last_byte)
            begin
                total_reg <= '0;
                for (int i = 0; i < KINDS; i++)
                    kcnt_reg[i] <= '0;
            end
            else if (emit)
            begin
                total_reg      <= total_next;
                kcnt_reg[kind] <= kcnt_next;
            end
        end
    end

endmodule

FILE: hdl/ethernet_frame_classifier.sv
// ethernet frame classifier top level: input register, parser, result register
// depends on efc_pkg and efc_parser
`timescale 1ns / 1ps

// Usage
// s_axis carries the captured byte stream, one byte per request; tlast marks
// the final byte of a capture, after which any partial frame is dropped and
// the frame and kind counters restart from zero.
// m_axis carries one result per complete frame: running frame number, kind,
// both MAC addresses, IPv4 addresses (zero for other kinds), running count of
// that kind and a flag for a length field that was raised to its minimum.
// Throughput is one byte per clock, set by the single parser pass between the
// input register and the result register, except while a byte is held as below.
// A frame's result is loaded into the result register as its final byte
// leaves the input register, when the result register is free.
// When the receiver holds m_axis_tready low the result stays in place; bytes
// that complete no frame keep flowing, and s_axis_tready drops only when a
// byte that completes a frame waits for a full result register.
// Reset clears all frame state and counters; nothing is shown on m_axis.
// Counters are COUNT_BITS wide and saturate; their low 32 bits are shown.

module ethernet_frame_classifier #(
    parameter int COUNT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // data_byte
    input  logic                             s_axis_tlast,  // last_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // frame_number[31:0], frame_kind[34:32], dest_mac[82:35], src_mac[130:83],
    // src_ip[162:131], dst_ip[194:163], kind_count[226:195],
    // length_raised[227], zero pad[231:228]
    output logic [efc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import efc_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic     advance;
    logic     emit;
    in_item_t item;
    result_t  result;

    // a byte with no result never waits on the output side
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign item.step      = advance;
    assign item.data_byte = in_byte_reg;
    assign item.last_byte = in_last_reg;

    efc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= {4'b0000,
                             result.length_raised,
                             result.kind_count,
                             result.dst_ip,
                             result.src_ip,
                             result.src_mac,
                             result.dest_mac,
                             result.frame_kind,
                             result.frame_number};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: hdl/efc_checker.sv
// port-level checks for the ethernet frame classifier, bound to the top level
// depends on efc_pkg and ethernet_frame_classifier_assert.svh
`timescale 1ns / 1ps
`include "ethernet_frame_classifier_assert.svh"

module efc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [efc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import efc_pkg::*;

    // stalled result stays offered and unchanged
    `EFC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
    `EFC_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

    // nothing offered once reset has been applied
    `EFC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "result offered during reset")

    // frame count and kind count include the frame itself
    `EFC_ASSERT(a_count_nonzero, m_axis_tvalid |-> m_axis_tdata[31:0] != 32'd0 && m_axis_tdata[226:195] != 32'd0, "zero running count on a result")

    // ip addresses only for ipv4 frames
    `EFC_ASSERT(a_ip_zero, m_axis_tvalid && m_axis_tdata[34:32] != KIND_IPV4 |-> m_axis_tdata[194:131] == 64'd0, "ip address on a non-ipv4 frame")

endmodule

bind ethernet_frame_classifier efc_checker u_efc_checker (.*);
